/* rtl/mmpt_pkg.sv */
// mmpt_pkg: shared constants and helpers for the manhattan minimax point tracker
// no dependencies; compile first
`default_nettype none

package mmpt_pkg;

	// default coordinate width of the point ports
	localparam int DEFAULT_COORD_BITS = 32;

	// the four rectangle corners tracked by the back end
	localparam int NUM_CORNERS = 4;
	localparam int CORNER_UL = 0; // (0, rect_width)
	localparam int CORNER_LL = 1; // (0, 0)
	localparam int CORNER_UR = 2; // (rect_length, rect_width)
	localparam int CORNER_LR = 3; // (rect_length, 0)

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_WIDTH  = 1'b1;

	// action codes of an input transaction
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// queue entry: action, x, y and one corner distance per corner
	function automatic int entry_bits(input int coord_bits);
		return 1 + 2 * coord_bits + NUM_CORNERS * (coord_bits + 1);
	endfunction

endpackage

`default_nettype wire

/* rtl/mmpt_ifs.sv */
// mmpt_point_if and mmpt_result_if: valid/ready channels of the point tracker
// no dependencies besides mmpt_pkg for the default width
`default_nettype none

interface mmpt_point_if #(
	parameter int COORD_BITS = mmpt_pkg::DEFAULT_COORD_BITS
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;

	modport source (output valid, action, pos_x, pos_y, input ready);
	modport sink   (input valid, action, pos_x, pos_y, output ready);
endinterface

interface mmpt_result_if #(
	parameter int COORD_BITS = mmpt_pkg::DEFAULT_COORD_BITS
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS:0]   farthest_dist;
	logic [COORD_BITS+1:0] best_dist;

	modport source (output valid, farthest_dist, best_dist, input ready);
	modport sink   (input valid, farthest_dist, best_dist, output ready);
endinterface

`default_nettype wire

/* rtl/mmpt_front.sv */
// mmpt_front: accepts point transactions, holds the rectangle config and
// computes the four corner distances; depends on mmpt_pkg and mmpt_ifs
`default_nettype none

module mmpt_front #(
	parameter int COORD_BITS = mmpt_pkg::DEFAULT_COORD_BITS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      cfg_we,
	input  wire logic [mmpt_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  wire logic [COORD_BITS-1:0]                     cfg_data,
	mmpt_point_if.sink                                     point,
	output logic                                           push_valid,
	input  wire logic                                      push_ready,
	output logic [mmpt_pkg::entry_bits(COORD_BITS)-1:0]    push_data
);

	localparam int DIST_BITS = COORD_BITS + 1;

	logic [COORD_BITS-1:0] rect_length_q;
	logic [COORD_BITS-1:0] rect_width_q;

	logic                  valid_s1;
	logic                  action_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [DIST_BITS-1:0]  dist_s1  [mmpt_pkg::NUM_CORNERS];
	logic [DIST_BITS-1:0]  dist_now [mmpt_pkg::NUM_CORNERS];

	logic [COORD_BITS-1:0] dx_right;
	logic [COORD_BITS-1:0] dy_upper;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		return (a > b) ? a - b : b - a;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_length_q <= '0;
			rect_width_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmpt_pkg::REG_RECT_LENGTH: rect_length_q <= cfg_data;
				mmpt_pkg::REG_RECT_WIDTH:  rect_width_q  <= cfg_data;
			endcase
		end
	end

	// distances from the incoming point to each corner
	always_comb begin
		dx_right = abs_diff(point.pos_x, rect_length_q);
		dy_upper = abs_diff(point.pos_y, rect_width_q);
		dist_now[mmpt_pkg::CORNER_UL] = {1'b0, point.pos_x} + {1'b0, dy_upper};
		dist_now[mmpt_pkg::CORNER_LL] = {1'b0, point.pos_x} + {1'b0, point.pos_y};
		dist_now[mmpt_pkg::CORNER_UR] = {1'b0, dx_right} + {1'b0, dy_upper};
		dist_now[mmpt_pkg::CORNER_LR] = {1'b0, dx_right} + {1'b0, point.pos_y};
	end

	assign point.ready = !valid_s1 || push_ready;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point.ready) begin
			valid_s1 <= point.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (point.valid && point.ready) begin
			action_s1 <= point.action;
			x_s1      <= point.pos_x;
			y_s1      <= point.pos_y;
			dist_s1   <= dist_now;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = {action_s1, x_s1, y_s1,
		dist_s1[mmpt_pkg::CORNER_UL], dist_s1[mmpt_pkg::CORNER_LL],
		dist_s1[mmpt_pkg::CORNER_UR], dist_s1[mmpt_pkg::CORNER_LR]};

endmodule

`default_nettype wire

/* rtl/mmpt_queue.sv */
// mmpt_queue: small fifo of classified transactions between front and back
// depends on mmpt_pkg for the depth
`default_nettype none

module mmpt_queue #(
	parameter int WIDTH = mmpt_pkg::entry_bits(mmpt_pkg::DEFAULT_COORD_BITS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int DEPTH    = mmpt_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push_fire;
	logic                pop_fire;

	assign push_ready = (count_q != CNT_BITS'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/mmpt_back.sv */
// mmpt_back: updates the nearest point per corner and answers queries with
// the farthest kept point and the running minimum; depends on mmpt_pkg, mmpt_ifs
`default_nettype none

module mmpt_back #(
	parameter int COORD_BITS = mmpt_pkg::DEFAULT_COORD_BITS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      pop_valid,
	output logic                                           pop_ready,
	input  wire logic [mmpt_pkg::entry_bits(COORD_BITS)-1:0] pop_data,
	mmpt_result_if.source                                  result
);

	localparam int DIST_BITS = COORD_BITS + 1;
	localparam int WIDE_BITS = COORD_BITS + 2;

	logic                  pop_action;
	logic [COORD_BITS-1:0] pop_x;
	logic [COORD_BITS-1:0] pop_y;
	logic [DIST_BITS-1:0]  pop_dist [mmpt_pkg::NUM_CORNERS];
	logic                  pop_fire;

	logic [WIDE_BITS-1:0]  corner_best_q [mmpt_pkg::NUM_CORNERS];
	logic [COORD_BITS-1:0] corner_x_q    [mmpt_pkg::NUM_CORNERS];
	logic [COORD_BITS-1:0] corner_y_q    [mmpt_pkg::NUM_CORNERS];

	logic                  query_s1;
	logic [DIST_BITS-1:0]  qdist_s1 [mmpt_pkg::NUM_CORNERS];
	logic [DIST_BITS-1:0]  qdist    [mmpt_pkg::NUM_CORNERS];

	logic                  out_valid_q;
	logic [DIST_BITS-1:0]  farthest_q;
	logic [WIDE_BITS-1:0]  best_q;
	logic [WIDE_BITS-1:0]  run_min_q;

	logic                  adv_out;
	logic [DIST_BITS-1:0]  max_lo;
	logic [DIST_BITS-1:0]  max_hi;
	logic [DIST_BITS-1:0]  far;
	logic [WIDE_BITS-1:0]  new_min;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		return (a > b) ? a - b : b - a;
	endfunction

	assign {pop_action, pop_x, pop_y,
		pop_dist[mmpt_pkg::CORNER_UL], pop_dist[mmpt_pkg::CORNER_LL],
		pop_dist[mmpt_pkg::CORNER_UR], pop_dist[mmpt_pkg::CORNER_LR]} = pop_data;

	// back pipeline handshake
	assign adv_out   = !out_valid_q || result.ready;
	assign pop_ready = !query_s1 || adv_out;
	assign pop_fire  = pop_valid && pop_ready;

	// nearest point per corner, strict compare keeps the earlier point on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mmpt_pkg::NUM_CORNERS; k++) begin
				corner_best_q[k] <= '1;
				corner_x_q[k]    <= '0;
				corner_y_q[k]    <= '0;
			end
		end else if (pop_fire && pop_action == mmpt_pkg::ACT_ADD) begin
			for (int k = 0; k < mmpt_pkg::NUM_CORNERS; k++) begin
				if ({1'b0, pop_dist[k]} < corner_best_q[k]) begin
					corner_best_q[k] <= {1'b0, pop_dist[k]};
					corner_x_q[k]    <= pop_x;
					corner_y_q[k]    <= pop_y;
				end
			end
		end
	end

	// query distances to the kept points
	always_comb begin
		for (int k = 0; k < mmpt_pkg::NUM_CORNERS; k++) begin
			qdist[k] = {1'b0, abs_diff(corner_x_q[k], pop_x)}
				+ {1'b0, abs_diff(corner_y_q[k], pop_y)};
		end
	end

	// query stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_s1 <= 1'b0;
		end else if (pop_ready) begin
			query_s1 <= pop_fire && (pop_action == mmpt_pkg::ACT_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire && pop_action == mmpt_pkg::ACT_QUERY) begin
			qdist_s1 <= qdist;
		end
	end

	// farthest kept point and running minimum
	always_comb begin
		max_lo  = (qdist_s1[0] > qdist_s1[1]) ? qdist_s1[0] : qdist_s1[1];
		max_hi  = (qdist_s1[2] > qdist_s1[3]) ? qdist_s1[2] : qdist_s1[3];
		far     = (max_lo > max_hi) ? max_lo : max_hi;
		new_min = ({1'b0, far} < run_min_q) ? {1'b0, far} : run_min_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_min_q   <= '1;
		end else if (adv_out) begin
			out_valid_q <= query_s1;
			if (query_s1) begin
				run_min_q <= new_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && query_s1) begin
			farthest_q <= far;
			best_q     <= new_min;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.farthest_dist = farthest_q;
	assign result.best_dist     = best_q;

endmodule

`default_nettype wire

/* rtl/manhattan_minimax_point_tracker_unit.sv */
// Manhattan minimax point tracker. Add transactions keep, for each corner of
// the configured rectangle, the nearest point seen so far (a tie keeps the
// earlier one); a query transaction returns the largest Manhattan distance to
// the four kept points and the minimum of that value over all queries so far.
// The block takes one transaction per cycle while the queue and the output do
// not stall, adds and queries mixed in any order. A query result passes the
// input stage, the queue, the query stage and the output register; adds give
// no result. A four-entry queue lets input and output stall apart.
// There is no clearing pass after reset; write rect_length and rect_width
// only while the block is idle.
// depends on mmpt_pkg, mmpt_ifs, mmpt_front, mmpt_queue, mmpt_back
`default_nettype none

module manhattan_minimax_point_tracker_unit #(
	parameter int COORD_BITS = mmpt_pkg::DEFAULT_COORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mmpt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-1:0]               cfg_data,
	mmpt_point_if.sink                               point,
	mmpt_result_if.source                            result
);

	localparam int ENTRY_BITS = mmpt_pkg::entry_bits(COORD_BITS);

	logic                  push_valid;
	logic                  push_ready;
	logic [ENTRY_BITS-1:0] push_data;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [ENTRY_BITS-1:0] pop_data;

	// accept and precompute corner distances
	mmpt_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.point      (point),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	mmpt_queue #(
		.WIDTH (ENTRY_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// corner update and query evaluation
	mmpt_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

`default_nettype wire

/* rtl/mmpt_checker.sv */
// mmpt_checker: port-level assertions for the point tracker, bound to the top
// depends on mmpt_pkg and manhattan_minimax_point_tracker_unit
`default_nettype none

module mmpt_checker #(
	parameter int COORD_BITS = mmpt_pkg::DEFAULT_COORD_BITS
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  in_action,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [COORD_BITS:0]   farthest_dist,
	input wire logic [COORD_BITS+1:0] best_dist
);

	logic [3:0]            pending_q;
	logic                  seen_q;
	logic [COORD_BITS+1:0] last_best_q;
	logic                  query_in;
	logic                  result_out;

	assign query_in   = in_valid && in_ready && (in_action == mmpt_pkg::ACT_QUERY);
	assign result_out = out_valid && out_ready;

	// queries accepted but not yet answered, and the last delivered minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (query_in && !result_out) begin
				pending_q <= pending_q + 1'b1;
			end else if (result_out && !query_in) begin
				pending_q <= pending_q - 1'b1;
			end
			if (result_out) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_out) begin
			last_best_q <= best_dist;
		end
	end

	// a result only answers an outstanding query
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without an outstanding query");

	// running minimum includes the current query
	a_best_le_farthest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, farthest_dist} >= best_dist)
		else $error("best_dist above farthest_dist");

	// running minimum never grows
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> best_dist <= last_best_q)
		else $error("best_dist increased");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(farthest_dist) && $stable(best_dist))
		else $error("stalled result changed");

endmodule

bind manhattan_minimax_point_tracker_unit mmpt_checker #(
	.COORD_BITS (COORD_BITS)
) u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (point.valid),
	.in_ready      (point.ready),
	.in_action     (point.action),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.farthest_dist (result.farthest_dist),
	.best_dist     (result.best_dist)
);

`default_nettype wire

/* bench/manhattan_minimax_point_tracker_unit_tb.sv */
// testbench for manhattan_minimax_point_tracker_unit: directed table plus random
// point streams, each query result checked against its table value or an in-bench corner tracker
// depends on mmpt_pkg, mmpt_ifs and the rtl of the tracker
`timescale 1ns / 1ps

module manhattan_minimax_point_tracker_unit_tb;
	import mmpt_pkg::*;

	localparam int          CB          = 32;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 20;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [31:0] HALF        = 32'h8000_0000;

	typedef struct packed {
		logic          action;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
	} point_t;

	typedef struct packed {
		logic [CB:0]   farthest;
		logic [CB+1:0] best;
	} dist_pair_t;

	typedef struct packed {
		point_t     pt;
		logic       typed;
		dist_pair_t want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CB-1:0]             cfg_data;

	mmpt_point_if  #(.COORD_BITS(CB)) point_ch ();
	mmpt_result_if #(.COORD_BITS(CB)) result_ch ();

	manhattan_minimax_point_tracker_unit #(.COORD_BITS(CB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point     (point_ch),
		.result    (result_ch)
	);

	// shadow of the rectangle and the kept corner points
	logic [CB-1:0] rect_len;
	logic [CB-1:0] rect_wid;
	logic [CB+1:0] corner_dist [NUM_CORNERS];
	logic [CB-1:0] corner_px [NUM_CORNERS];
	logic [CB-1:0] corner_py [NUM_CORNERS];
	logic [CB+1:0] query_min;

	dist_pair_t  expected_dists [$];
	dist_pair_t  oldest;
	stim_row_t   directed_rows [0:14];

	int unsigned errors;
	int unsigned adds_sent;
	int unsigned queries_sent;
	int unsigned results_checked;
	int unsigned cycle_count;
	int unsigned settings_used;
	bit          send_calm;
	bit          recv_calm;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CB:0] taxicab(input logic [CB-1:0] ax, input logic [CB-1:0] ay,
			input logic [CB-1:0] bx, input logic [CB-1:0] by);
		logic [CB-1:0] dx;
		logic [CB-1:0] dy;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		return {1'b0, dx} + {1'b0, dy};
	endfunction

	// corner update for an add, farthest kept point and running minimum for a query
	function automatic void track_point(input point_t p, output bit has_res,
			output dist_pair_t r);
		logic [CB-1:0] cx [NUM_CORNERS];
		logic [CB-1:0] cy [NUM_CORNERS];
		logic [CB:0]   d;
		logic [CB:0]   widest;
		cx[CORNER_UL] = '0;       cy[CORNER_UL] = rect_wid;
		cx[CORNER_LL] = '0;       cy[CORNER_LL] = '0;
		cx[CORNER_UR] = rect_len; cy[CORNER_UR] = rect_wid;
		cx[CORNER_LR] = rect_len; cy[CORNER_LR] = '0;
		has_res = 1'b0;
		r = '0;
		if (p.action == ACT_ADD) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				d = taxicab(p.x, p.y, cx[k], cy[k]);
				// strict compare, a tie keeps the earlier point
				if ({1'b0, d} < corner_dist[k]) begin
					corner_dist[k] = {1'b0, d};
					corner_px[k] = p.x;
					corner_py[k] = p.y;
				end
			end
		end else begin
			widest = '0;
			for (int k = 0; k < NUM_CORNERS; k++) begin
				d = taxicab(corner_px[k], corner_py[k], p.x, p.y);
				if (d > widest)
					widest = d;
			end
			if ({1'b0, widest} < query_min)
				query_min = {1'b0, widest};
			has_res = 1'b1;
			r.farthest = widest;
			r.best = query_min;
		end
	endfunction

	// coordinate near an anchor with log-spread offset, or random, or an extreme
	function automatic logic [CB-1:0] pick_coord(input logic [CB-1:0] anchor);
		int unsigned sel;
		logic [CB:0] off;
		logic [CB:0] sum;
		sel = $urandom_range(0, 9);
		off = {1'b0, $urandom} >> $urandom_range(0, 27);
		if (sel < 3)
			return $urandom;
		else if (sel == 3)
			return '0;
		else if (sel == 4)
			return ALL_ONES;
		else if ($urandom_range(0, 1) == 0) begin
			sum = {1'b0, anchor} + off;
			return sum[CB] ? ALL_ONES : sum[CB-1:0];
		end else
			return ({1'b0, anchor} > off) ? anchor - off[CB-1:0] : '0;
	endfunction

	// one register write, left with the enable high for a following write
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CB-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_RECT_LENGTH)
			rect_len = val;
		else
			rect_wid = val;
	endtask

	// wait for the block to drain, then move the rectangle
	task automatic set_rect(input logic [CB-1:0] len, input logic [CB-1:0] wid);
		while (expected_dists.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_RECT_LENGTH, len);
		write_reg(REG_RECT_WIDTH, wid);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// one point transaction; valid stays high so a back-to-back item needs no gap
	task automatic send_point(input point_t p, input logic typed, input dist_pair_t want);
		int unsigned gap;
		bit          has_res;
		dist_pair_t  pred;
		gap = send_calm ? 0 : $urandom_range(0, 11);
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		if (gap != 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_ch.valid <= 1'b1;
		point_ch.action <= p.action;
		point_ch.pos_x <= p.x;
		point_ch.pos_y <= p.y;
		do
			@(posedge clk);
		while (!point_ch.ready);
		track_point(p, has_res, pred);
		if (has_res) begin
			expected_dists.push_back(typed ? want : pred);
			queries_sent++;
		end else
			adds_sent++;
	endtask

	task automatic run_random(input logic [CB-1:0] len, input logic [CB-1:0] wid,
			input int unsigned count);
		point_t p;
		set_rect(len, wid);
		for (int unsigned i = 0; i < count; i++) begin
			p.action = ($urandom_range(0, 99) < 55) ? ACT_ADD : ACT_QUERY;
			p.x = pick_coord($urandom_range(0, 1) ? rect_len : '0);
			p.y = pick_coord($urandom_range(0, 1) ? rect_wid : '0);
			send_point(p, 1'b0, '0);
		end
		point_ch.valid <= 1'b0;
	endtask

	// result side: random stalls, with calm stretches
	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_ch.valid);
		end
	end

	// compare each result transaction with the oldest pending query
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_dists.size() == 0) begin
				errors++;
				$display("%0t: result with no query pending: farthest %h best %h", $time,
					result_ch.farthest_dist, result_ch.best_dist);
			end else begin
				oldest = expected_dists.pop_front();
				results_checked++;
				if (result_ch.farthest_dist !== oldest.farthest) begin
					errors++;
					$display("%0t: farthest_dist mismatch: expected %h actual %h", $time,
						oldest.farthest, result_ch.farthest_dist);
				end
				if (result_ch.best_dist !== oldest.best) begin
					errors++;
					$display("%0t: best_dist mismatch: expected %h actual %h", $time,
						oldest.best, result_ch.best_dist);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d query results outstanding", $time,
				expected_dists.size());
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		errors = 0;
		adds_sent = 0;
		queries_sent = 0;
		results_checked = 0;
		cycle_count = 0;
		settings_used = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		rect_len = '0;
		rect_wid = '0;
		for (int k = 0; k < NUM_CORNERS; k++) begin
			corner_dist[k] = '1;
			corner_px[k] = '0;
			corner_py[k] = '0;
		end
		query_min = '1;

		// directed rows run with the rectangle at (2^31, 2^31)
		directed_rows = '{
			// query before any add measures to the origin
			'{'{ACT_QUERY, ALL_ONES, ALL_ONES}, 1'b1, '{33'h1_FFFF_FFFE, 34'h1_FFFF_FFFE}},
			'{'{ACT_QUERY, 32'h0, ALL_ONES},    1'b1, '{33'h0_FFFF_FFFF, 34'h0_FFFF_FFFF}},
			// first add fills every corner
			'{'{ACT_ADD, 32'h4000_0000, 32'h4000_0000}, 1'b0, '0},
			'{'{ACT_QUERY, ALL_ONES, ALL_ONES}, 1'b1, '{33'h1_7FFF_FFFE, 34'h0_FFFF_FFFF}},
			// point outside the rectangle
			'{'{ACT_ADD, ALL_ONES, ALL_ONES}, 1'b0, '0},
			// tie at the lower left corner keeps the first of the pair
			'{'{ACT_ADD, 32'h1000_0000, 32'h2000_0000}, 1'b0, '0},
			'{'{ACT_ADD, 32'h2000_0000, 32'h1000_0000}, 1'b0, '0},
			'{'{ACT_QUERY, 32'h0, 32'h0}, 1'b0, '0},
			'{'{ACT_QUERY, ALL_ONES, 32'h0}, 1'b0, '0},
			'{'{ACT_QUERY, HALF, HALF}, 1'b0, '0},
			'{'{ACT_ADD, 32'h0, ALL_ONES}, 1'b0, '0},
			'{'{ACT_ADD, ALL_ONES, 32'h0}, 1'b0, '0},
			'{'{ACT_QUERY, 32'h7FFF_FFFF, 32'h8000_0001}, 1'b0, '0},
			'{'{ACT_QUERY, 32'h0, ALL_ONES}, 1'b0, '0},
			'{'{ACT_QUERY, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, '0}
		};

		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RECT_LENGTH;
		cfg_data <= '0;
		point_ch.valid <= 1'b0;
		point_ch.action <= ACT_ADD;
		point_ch.pos_x <= '0;
		point_ch.pos_y <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_rect(HALF, HALF);
		foreach (directed_rows[i])
			send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
		point_ch.valid <= 1'b0;

		// random phases, wide rectangles first so the kept distances shrink gradually
		run_random(ALL_ONES, ALL_ONES, 305);
		run_random($urandom, $urandom, 305);
		run_random(ALL_ONES, 32'h0, 305);
		run_random(32'h0, ALL_ONES, 305);
		run_random($urandom_range(1, 5000), $urandom_range(1, 5000), 305);
		run_random(32'h0, 32'h0, 305);

		while (expected_dists.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d adds and %0d queries over %0d rectangle settings",
			adds_sent, queries_sent, settings_used);
		$display("compared %0d query results, %0d mismatches", results_checked, errors);
		if (errors == 0 && expected_dists.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/mmpt_pkg.sv
rtl/mmpt_ifs.sv
rtl/mmpt_front.sv
rtl/mmpt_queue.sv
rtl/mmpt_back.sv
rtl/manhattan_minimax_point_tracker_unit.sv
rtl/mmpt_checker.sv
bench/manhattan_minimax_point_tracker_unit_tb.sv
